// File: src/pes_pkg.sv
// Shared types and constants for the periodic event scheduler.
// Used by every module of the block; depends on nothing else.
package pes_pkg;

  localparam int MAX_ENTRIES = 64;
  localparam int IDX_W       = $clog2(MAX_ENTRIES);
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);

  localparam int ID_W   = 16;
  localparam int PER_W  = 16;
  localparam int TIME_W = 32;
  localparam int ST_W   = 2;

  localparam logic [TIME_W-1:0] TIME_MAX = '1;

  typedef enum logic [0:0] {
    OP_REGISTER = 1'b0,
    OP_NEXT     = 1'b1
  } op_t;

  typedef enum logic [ST_W-1:0] {
    ST_REGISTERED = 2'd0,
    ST_FIRED      = 2'd1,
    ST_FULL       = 2'd2,
    ST_EMPTY      = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_SCAN,
    S_WRITEBACK,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [PER_W-1:0]  period;
    logic [TIME_W-1:0] due;
  } slot_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    slot_t            data;
  } ram_wr_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
  } ram_rd_t;

  typedef struct packed {
    logic             take;
    logic             first;
    logic [IDX_W-1:0] idx;
  } best_ctl_t;

endpackage

// File: src/pes_slot_ram.sv
// Entry table: one write port and one read port with registered read data.
// Depends on pes_pkg for the slot layout and the table depth.
module pes_slot_ram (
  input  logic              clk,
  input  pes_pkg::ram_wr_t  wr,
  input  pes_pkg::ram_rd_t  rd,
  output pes_pkg::slot_t    rd_data
);
  import pes_pkg::*;

  slot_t slot_mem [MAX_ENTRIES];
  slot_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      slot_mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd.en) begin
      rd_data_r <= slot_mem[rd.addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: src/pes_best_unit.sv
// Compare unit that keeps the earliest entry seen during a scan,
// plus the saturating reschedule add for that entry. Depends on pes_pkg.
module pes_best_unit (
  input  logic                          clk,
  input  pes_pkg::best_ctl_t            ctl,
  input  pes_pkg::slot_t                cand,
  output pes_pkg::slot_t                best,
  output logic [pes_pkg::IDX_W-1:0]     best_idx,
  output logic [pes_pkg::TIME_W-1:0]    next_due
);
  import pes_pkg::*;

  slot_t            best_r;
  slot_t            best_nxt;
  logic [IDX_W-1:0] best_idx_r;
  logic [IDX_W-1:0] best_idx_nxt;
  logic             better;
  logic [TIME_W:0]  sum;

  // Strictly earlier wins; on equal due time the smaller id wins, and a full
  // tie keeps the lower slot that was seen first.
  always_comb begin
    better = (cand.due < best_r.due) ||
             ((cand.due == best_r.due) && (cand.id < best_r.id));
    best_nxt     = best_r;
    best_idx_nxt = best_idx_r;
    if (ctl.take && (ctl.first || better)) begin
      best_nxt     = cand;
      best_idx_nxt = ctl.idx;
    end
  end

  always_ff @(posedge clk) begin
    best_r     <= best_nxt;
    best_idx_r <= best_idx_nxt;
  end

  always_comb begin
    sum      = {1'b0, best_r.due} + {{(TIME_W + 1 - PER_W){1'b0}}, best_r.period};
    next_due = sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];
  end

  assign best     = best_r;
  assign best_idx = best_idx_r;

endmodule

// File: src/periodic_event_scheduler_unit.sv
// Top level of the periodic event scheduler: sequencer, entry count and
// output register. Uses pes_pkg, pes_slot_ram and pes_best_unit.
//
//   channel | direction | handshake        | payload
//   --------+-----------+------------------+-----------------------------------
//   in_     | input     | in_valid/in_stall| opcode, query_id, period
//   out_    | output    | out_valid/out_stall | status, fired_id, fired_time
//
// A register item, or any item that reports full or empty, passes through the
// dispatch and done states before its result sits in the output register.
// A next item goes through dispatch, scan, writeback and done; it scans the table
// one entry per cycle through the single read port of the entry memory.
// After reset the entry count is zero; the table needs no clearing pass.
// A stalled result holds in the output register; the next item is accepted
// once the sequencer is idle, even while that result still waits.
module periodic_event_scheduler_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        in_opcode,
  input  logic [pes_pkg::ID_W-1:0]    in_query_id,
  input  logic [pes_pkg::PER_W-1:0]   in_period,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [pes_pkg::ST_W-1:0]    out_status,
  output logic [pes_pkg::ID_W-1:0]    out_fired_id,
  output logic [pes_pkg::TIME_W-1:0]  out_fired_time
);
  import pes_pkg::*;

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  op_t               op_r, op_nxt;
  logic [ID_W-1:0]   id_r, id_nxt;
  logic [PER_W-1:0]  per_r, per_nxt;
  logic [CNT_W-1:0]  iss_r, iss_nxt;
  logic              rd_vld_r, rd_vld_nxt;
  logic [IDX_W-1:0]  rd_idx_r, rd_idx_nxt;
  status_t           res_status_r, res_status_nxt;
  logic [ID_W-1:0]   res_id_r, res_id_nxt;
  logic [TIME_W-1:0] res_time_r, res_time_nxt;
  logic              out_valid_r, out_valid_nxt;
  status_t           out_status_r, out_status_nxt;
  logic [ID_W-1:0]   out_id_r, out_id_nxt;
  logic [TIME_W-1:0] out_time_r, out_time_nxt;

  ram_wr_t           ram_wr;
  ram_rd_t           ram_rd;
  slot_t             ram_rd_data;
  best_ctl_t         best_ctl;
  slot_t             best;
  logic [IDX_W-1:0]  best_idx;
  logic [TIME_W-1:0] next_due;
  logic              last_read;
  logic              out_free;

  pes_slot_ram u_ram (
    .clk     (clk),
    .wr      (ram_wr),
    .rd      (ram_rd),
    .rd_data (ram_rd_data)
  );

  pes_best_unit u_best (
    .clk      (clk),
    .ctl      (best_ctl),
    .cand     (ram_rd_data),
    .best     (best),
    .best_idx (best_idx),
    .next_due (next_due)
  );

  assign last_read = rd_vld_r && (CNT_W'(rd_idx_r) == (count_r - 1'b1));
  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != S_IDLE);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (op_r == OP_NEXT && count_r != '0) begin
          state_nxt = S_SCAN;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_SCAN: begin
        if (last_read) begin
          state_nxt = S_WRITEBACK;
        end
      end
      S_WRITEBACK: state_nxt = S_DONE;
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Datapath control per state.
  always_comb begin
    count_nxt      = count_r;
    op_nxt         = op_r;
    id_nxt         = id_r;
    per_nxt        = per_r;
    iss_nxt        = iss_r;
    rd_vld_nxt     = rd_vld_r;
    rd_idx_nxt     = rd_idx_r;
    res_status_nxt = res_status_r;
    res_id_nxt     = res_id_r;
    res_time_nxt   = res_time_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_status_nxt = out_status_r;
    out_id_nxt     = out_id_r;
    out_time_nxt   = out_time_r;
    ram_wr         = '0;
    ram_rd         = '0;
    best_ctl       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt  = op_t'(in_opcode);
          id_nxt  = in_query_id;
          per_nxt = in_period;
        end
      end
      S_DISPATCH: begin
        res_id_nxt   = '0;
        res_time_nxt = '0;
        if (op_r == OP_REGISTER) begin
          if (count_r == CNT_W'(MAX_ENTRIES)) begin
            res_status_nxt = ST_FULL;
          end else begin
            ram_wr.en          = 1'b1;
            ram_wr.addr        = count_r[IDX_W-1:0];
            ram_wr.data.id     = id_r;
            ram_wr.data.period = per_r;
            ram_wr.data.due    = {{(TIME_W - PER_W){1'b0}}, per_r};
            count_nxt          = count_r + 1'b1;
            res_status_nxt     = ST_REGISTERED;
          end
        end else if (count_r == '0) begin
          res_status_nxt = ST_EMPTY;
        end else begin
          ram_rd.en   = 1'b1;
          ram_rd.addr = '0;
          rd_vld_nxt  = 1'b1;
          rd_idx_nxt  = '0;
          iss_nxt     = CNT_W'(1);
        end
      end
      S_SCAN: begin
        best_ctl.take  = rd_vld_r;
        best_ctl.first = (rd_idx_r == '0);
        best_ctl.idx   = rd_idx_r;
        if (iss_r < count_r) begin
          ram_rd.en   = 1'b1;
          ram_rd.addr = iss_r[IDX_W-1:0];
          rd_vld_nxt  = 1'b1;
          rd_idx_nxt  = iss_r[IDX_W-1:0];
          iss_nxt     = iss_r + 1'b1;
        end else begin
          rd_vld_nxt = 1'b0;
        end
      end
      S_WRITEBACK: begin
        ram_wr.en          = 1'b1;
        ram_wr.addr        = best_idx;
        ram_wr.data.id     = best.id;
        ram_wr.data.period = best.period;
        ram_wr.data.due    = next_due;
        res_status_nxt     = ST_FIRED;
        res_id_nxt         = best.id;
        res_time_nxt       = best.due;
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_id_nxt     = res_id_r;
          out_time_nxt   = res_time_r;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      rd_vld_r    <= rd_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    id_r         <= id_nxt;
    per_r        <= per_nxt;
    iss_r        <= iss_nxt;
    rd_idx_r     <= rd_idx_nxt;
    res_status_r <= res_status_nxt;
    res_id_r     <= res_id_nxt;
    res_time_r   <= res_time_nxt;
    out_status_r <= out_status_nxt;
    out_id_r     <= out_id_nxt;
    out_time_r   <= out_time_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_fired_id   = out_id_r;
  assign out_fired_time = out_time_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_ENTRIES))
    else $error("entry count above table depth");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && count_r != $past(count_r)) |->
      (count_r == $past(count_r) + 1'b1 && $past(state_r) == S_DISPATCH))
    else $error("entry count changed other than by one register");

  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_DONE)
    else $error("result appeared outside the done state");

  a_fired_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r == ST_FIRED) |-> count_r != '0)
    else $error("fired result with an empty table");

endmodule
